[rtl/core/dwtm_pkg.sv]
// Shared widths, constants, register codes and control types of the dual wavetable tone mixer.
package dwtm_pkg;

	// Field widths
	localparam int STEP_W   = 25;
	localparam int FRAC_W   = 16;
	localparam int GAIN_W   = 12;
	localparam int DAC_W    = 12;
	localparam int SAMPLE_W = 16;

	// Output scaling
	localparam int OUT_SHIFT = 17;
	localparam int MIDSCALE  = 2048;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_STEP_CHAN_A = 1'b0,
		REG_STEP_CHAN_B = 1'b1
	} reg_idx_t;

	// Step register write for one channel
	typedef struct packed {
		logic              en;
		logic [STEP_W-1:0] data;
	} cfg_wr_t;

endpackage

[rtl/core/dwtm_gain_if.sv]
// Input channel: one sample tick carrying the volume.
interface dwtm_gain_if;
	logic                        valid;
	logic                        ready;
	logic [dwtm_pkg::GAIN_W-1:0] gain_level;

	modport source (output valid, output gain_level, input ready);
	modport sink (input valid, input gain_level, output ready);
endinterface

[rtl/core/dwtm_dac_if.sv]
// Output channel: one 12-bit DAC code per tick.
interface dwtm_dac_if;
	logic                       valid;
	logic                       ready;
	logic [dwtm_pkg::DAC_W-1:0] dac_sample;

	modport source (output valid, output dac_sample, input ready);
	modport sink (input valid, input dac_sample, output ready);
endinterface

[rtl/core/dwtm_phase_acc.sv]
// Phase accumulator of one channel: step register, wrapped 10.16 phase and table index.
module dwtm_phase_acc #(
	parameter int TABLE_SIZE = 1000
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dwtm_pkg::cfg_wr_t                 cfg,
	input  logic                              advance,
	output logic [$clog2(TABLE_SIZE)-1:0]     idx
);
	import dwtm_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int PHASE_W = IDX_W + FRAC_W;
	localparam int INT_W   = STEP_W - FRAC_W;
	localparam logic [PHASE_W:0] SPAN = (PHASE_W+1)'(TABLE_SIZE * (1 << FRAC_W));

	logic [PHASE_W-1:0] step_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] step_red;
	logic [PHASE_W:0]   phase_sum;
	logic [PHASE_W-1:0] phase_nxt;

	// Reduce the integer part of a written step modulo the table size
	// (only matters for tables smaller than the step's integer range)
	always_comb begin
		logic [INT_W-1:0] x;
		x = cfg.data[STEP_W-1:FRAC_W];
		for (int k = INT_W - 1; k >= 0; k--) begin
			if ((TABLE_SIZE << k) < (1 << INT_W)) begin
				if (x >= INT_W'(TABLE_SIZE << k)) begin
					x = x - INT_W'(TABLE_SIZE << k);
				end
			end
		end
		step_red = PHASE_W'({x, cfg.data[FRAC_W-1:0]});
	end

	// Phase add with a single wrap; both terms stay below the span
	always_comb begin
		phase_sum = {1'b0, phase_q} + {1'b0, step_q};
		if (phase_sum >= SPAN) begin
			phase_sum = phase_sum - SPAN;
		end
		phase_nxt = phase_sum[PHASE_W-1:0];
	end

	assign idx = phase_nxt[PHASE_W-1:FRAC_W];

	// Step and phase registers; a zero step write clears the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			phase_q <= '0;
		end else if (cfg.en) begin
			step_q <= step_red;
			if (cfg.data == '0) begin
				phase_q <= '0;
			end
		end else if (advance) begin
			phase_q <= phase_nxt;
		end
	end

endmodule

[rtl/core/dwtm_sine_rom.sv]
// Dual-read sine ROM with registered outputs, contents built at elaboration.
module dwtm_sine_rom #(
	parameter int TABLE_SIZE = 1000
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [$clog2(TABLE_SIZE)-1:0]        idx_a,
	input  logic [$clog2(TABLE_SIZE)-1:0]        idx_b,
	output logic signed [dwtm_pkg::SAMPLE_W-1:0] data_a,
	output logic signed [dwtm_pkg::SAMPLE_W-1:0] data_b
);
	import dwtm_pkg::*;

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam logic [63:0] AMPLITUDE   = 64'd32767;

	// (a*b) >> 62, keeping the low 64 bits
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// sin((pi/2) * r / TABLE_SIZE) in Q62 by Taylor series
	function automatic logic [63:0] quarter_sine(input logic [31:0] r);
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] sum;
		th = (HALF_PI_Q62 / 64'(TABLE_SIZE)) * {32'd0, r}
			+ ((HALF_PI_Q62 % 64'(TABLE_SIZE)) * {32'd0, r}) / 64'(TABLE_SIZE);
		th2  = mul_q62(th, th);
		term = th;
		sum  = th;
		for (int n = 1; n < 40; n++) begin
			if (term != '0) begin
				term = mul_q62(term, th2) / 64'((2 * n) * (2 * n + 1));
				if ((n & 1) != 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		return sum;
	endfunction

	// One entry: quadrant folding around the quarter-wave series
	function automatic logic [SAMPLE_W-1:0] rom_entry(input int i);
		int          q;
		int          r;
		logic [63:0] m;
		logic [15:0] mag;
		q = (4 * i) / TABLE_SIZE;
		r = 4 * i - q * TABLE_SIZE;
		if (r == 0) begin
			mag = ((q & 1) != 0) ? 16'(AMPLITUDE) : 16'd0;
		end else begin
			m   = mul_q62(quarter_sine(32'(((q & 1) != 0) ? (TABLE_SIZE - r) : r)), AMPLITUDE);
			mag = m[15:0];
		end
		return (q >= 2) ? (16'd0 - mag) : mag;
	endfunction

	function automatic logic [TABLE_SIZE*SAMPLE_W-1:0] build_rom();
		logic [TABLE_SIZE*SAMPLE_W-1:0] bits;
		bits = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			bits[i*SAMPLE_W +: SAMPLE_W] = rom_entry(i);
		end
		return bits;
	endfunction

	localparam logic [TABLE_SIZE*SAMPLE_W-1:0] ROM_BITS = build_rom();

	// Registered reads, one per channel
	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= ROM_BITS[int'(idx_a)*SAMPLE_W +: SAMPLE_W];
			data_b <= ROM_BITS[int'(idx_b)*SAMPLE_W +: SAMPLE_W];
		end
	end

endmodule

[rtl/core/dwtm_mixer.sv]
// Mixer: sums the two tones, scales by volume, shifts to DAC range and registers the code.
module dwtm_mixer (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [dwtm_pkg::SAMPLE_W-1:0] rom_a,
	input  logic signed [dwtm_pkg::SAMPLE_W-1:0] rom_b,
	input  logic [dwtm_pkg::GAIN_W-1:0]          gain,
	output logic [dwtm_pkg::DAC_W-1:0]           dac_s2
);
	import dwtm_pkg::*;

	localparam int SUM_W  = SAMPLE_W + 1;
	localparam int PROD_W = SUM_W + GAIN_W + 1;

	logic signed [SUM_W-1:0]  tone_sum;
	logic signed [PROD_W-1:0] prod;
	logic [DAC_W-1:0]         code;

	// Sum, scale, floor shift; the low DAC bits of the shifted value plus midscale
	always_comb begin
		tone_sum = SUM_W'(rom_a) + SUM_W'(rom_b);
		prod     = PROD_W'(tone_sum) * PROD_W'(signed'({1'b0, gain}));
		code     = prod[OUT_SHIFT +: DAC_W] + DAC_W'(MIDSCALE);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (en) begin
			dac_s2 <= code;
		end
	end

endmodule

[rtl/core/dual_wavetable_tone_mixer.sv]
// Top level of the two-channel wavetable tone mixer (direct digital synthesis).
// Path: a transferred tick goes through the ROM read register, then the mix register.
// Throughput: one tick per cycle unless stalled; set by the phase add and registered ROM read.
// Reset: phases and step registers clear to zero and the pipeline empties; the ROM is constant.
// A result that waits on the output does not block a new tick while stage one is free.
module dual_wavetable_tone_mixer #(
	parameter int TABLE_SIZE = 1000
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [0:0]                  cfg_index,
	input  logic [dwtm_pkg::STEP_W-1:0] cfg_data,
	dwtm_gain_if.sink                   ticks,
	dwtm_dac_if.source                  samples
);
	import dwtm_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);

	cfg_wr_t                    wr_a;
	cfg_wr_t                    wr_b;
	logic                       accept;
	logic                       en_s1;
	logic                       en_s2;
	logic                       valid_s1;
	logic                       valid_s2;
	logic [GAIN_W-1:0]          gain_s1;
	logic [IDX_W-1:0]           idx_a;
	logic [IDX_W-1:0]           idx_b;
	logic signed [SAMPLE_W-1:0] rom_a_s1;
	logic signed [SAMPLE_W-1:0] rom_b_s1;
	logic [DAC_W-1:0]           dac_s2;

	// Register write decode
	always_comb begin
		wr_a.en   = cfg_wen && (cfg_index == REG_STEP_CHAN_A);
		wr_a.data = cfg_data;
		wr_b.en   = cfg_wen && (cfg_index == REG_STEP_CHAN_B);
		wr_b.data = cfg_data;
	end

	// Stage enables: each stage moves when the one after it can take its item
	assign en_s2       = !valid_s2 || samples.ready;
	assign en_s1       = !valid_s1 || en_s2;
	assign ticks.ready = en_s1;
	assign accept      = ticks.valid && en_s1;

	dwtm_phase_acc #(.TABLE_SIZE(TABLE_SIZE)) u_phase_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (wr_a),
		.advance (accept),
		.idx     (idx_a)
	);

	dwtm_phase_acc #(.TABLE_SIZE(TABLE_SIZE)) u_phase_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (wr_b),
		.advance (accept),
		.idx     (idx_b)
	);

	dwtm_sine_rom #(.TABLE_SIZE(TABLE_SIZE)) u_rom (
		.clk    (clk),
		.en     (accept),
		.idx_a  (idx_a),
		.idx_b  (idx_b),
		.data_a (rom_a_s1),
		.data_b (rom_b_s1)
	);

	// Volume travels alongside the ROM read
	always_ff @(posedge clk) begin
		if (accept) begin
			gain_s1 <= ticks.gain_level;
		end
	end

	dwtm_mixer u_mixer (
		.clk    (clk),
		.en     (en_s2 && valid_s1),
		.rom_a  (rom_a_s1),
		.rom_b  (rom_b_s1),
		.gain   (gain_s1),
		.dac_s2 (dac_s2)
	);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= ticks.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign samples.valid      = valid_s2;
	assign samples.dac_sample = dac_s2;

`ifndef NO_ASSERTIONS
	// ROM indexes never leave the table
	a_idx_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(idx_a) < TABLE_SIZE) && (int'(idx_b) < TABLE_SIZE))
		else $error("phase index outside sine table");

	// A tick transfer always lands in stage one
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted tick lost before stage one");

	// Both stages full and output stalled: no new tick may be taken
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !samples.ready) |-> !ticks.ready)
		else $error("tick taken while pipeline full");

	// A stalled result keeps its code until transferred
	a_stall_holds_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !samples.ready) |=> (valid_s2 && $stable(dac_s2)))
		else $error("stalled result changed");
`endif

endmodule
